FILE: sv/cll_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cursor linked-list engine.
// No dependencies; every other file imports this package.
package cll_pkg;

  localparam int NODES_DEF = 256;

  typedef enum logic [1:0] {
    OP_MAKE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ALLOC1,
    S_ALLOC2,
    S_MKWR,
    S_INS1,
    S_INS2,
    S_WCHK,
    S_WCMP,
    S_DF1,
    S_DF2,
    S_RESP
  } state_t;

  // link store read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LKQ,
    RD_AFTER,
    RD_HEAD
  } rd_sel_t;

  // link store write address source
  typedef enum logic [2:0] {
    WA_ZERO,
    WA_T,
    WA_AFTER,
    WA_PREV,
    WA_INI
  } wa_sel_t;

  // link store write data source
  typedef enum logic [1:0] {
    WD_LKQ,
    WD_ZERO,
    WD_T,
    WD_INI
  } wd_sel_t;

  typedef struct packed {
    logic       latch;
    logic       init_wr;
    logic       lk_rd;
    rd_sel_t    rd_sel;
    logic       lk_wr;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    logic       val_wr;
    logic       val_rd;
    logic       t_ld;
    logic       prev_head;
    logic       prev_t;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       res_ld;
    logic       res_t;
    logic [1:0] res_status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic after_ok;
    logic head_ok;
    logic lkq_zero;
    logic val_eq;
    logic cnt_full;
    logic init_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/cll_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on cll_pkg.
interface cll_in_if import cll_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] value;
  logic [7:0]  list_head;
  logic [7:0]  after_node;

  modport source (output valid, output op, output value, output list_head,
                  output after_node, input ready);
  modport sink (input valid, input op, input value, input list_head,
                input after_node, output ready);
endinterface

interface cll_out_if import cll_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] node;
  logic [1:0] status;

  modport source (output valid, output node, output status, input ready);
  modport sink (input valid, input node, input status, output ready);
endinterface

FILE: sv/cll_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the linked-list engine: steps each operation through the
// datapath by command words. Depends on cll_pkg.
module cll_ctrl import cll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   if (sts.init_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (sts.op)
          OP_MAKE:   state_nxt = S_ALLOC1;
          OP_INSERT: state_nxt = sts.after_ok ? S_ALLOC1 : S_RESP;
          default:   state_nxt = sts.head_ok ? S_WCHK : S_RESP;
        endcase
      end
      S_ALLOC1: state_nxt = sts.lkq_zero ? S_RESP : S_ALLOC2;
      S_ALLOC2: state_nxt = (sts.op == OP_MAKE) ? S_MKWR : S_INS1;
      S_MKWR:   state_nxt = S_RESP;
      S_INS1:   state_nxt = S_INS2;
      S_INS2:   state_nxt = S_RESP;
      S_WCHK:   state_nxt = (sts.lkq_zero || sts.cnt_full) ? S_RESP : S_WCMP;
      S_WCMP: begin
        if (!sts.val_eq) begin
          state_nxt = S_WCHK;
        end else if (sts.op == OP_DELETE) begin
          state_nxt = S_DF1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DF1:    state_nxt = S_DF2;
      S_DF2:    state_nxt = S_RESP;
      S_RESP:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.lk_wr   = 1'b1;
        cmd.wa_sel  = WA_INI;
        cmd.wd_sel  = WD_INI;
      end
      S_IDLE: cmd.latch = in_valid;
      S_DECODE: begin
        unique case (sts.op)
          OP_MAKE: begin
            cmd.lk_rd  = 1'b1;
            cmd.rd_sel = RD_ZERO;
          end
          OP_INSERT: begin
            if (sts.after_ok) begin
              cmd.lk_rd  = 1'b1;
              cmd.rd_sel = RD_ZERO;
            end else begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_MISS;
            end
          end
          default: begin
            if (sts.head_ok) begin
              cmd.lk_rd     = 1'b1;
              cmd.rd_sel    = RD_HEAD;
              cmd.prev_head = 1'b1;
              cmd.cnt_clr   = 1'b1;
            end else begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_MISS;
            end
          end
        endcase
      end
      S_ALLOC1: begin
        cmd.t_ld = 1'b1;
        if (sts.lkq_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_FULL;
        end else begin
          cmd.lk_rd  = 1'b1;
          cmd.rd_sel = RD_LKQ;
        end
      end
      S_ALLOC2: begin
        // unhook the new node from the free list
        cmd.lk_wr  = 1'b1;
        cmd.wa_sel = WA_ZERO;
        cmd.wd_sel = WD_LKQ;
        if (sts.op != OP_MAKE) begin
          cmd.val_wr = 1'b1;
          cmd.lk_rd  = 1'b1;
          cmd.rd_sel = RD_AFTER;
        end
      end
      S_MKWR: begin
        cmd.lk_wr      = 1'b1;
        cmd.wa_sel     = WA_T;
        cmd.wd_sel     = WD_ZERO;
        cmd.res_ld     = 1'b1;
        cmd.res_t      = 1'b1;
        cmd.res_status = ST_OK;
      end
      S_INS1: begin
        cmd.lk_wr  = 1'b1;
        cmd.wa_sel = WA_T;
        cmd.wd_sel = WD_LKQ;
      end
      S_INS2: begin
        cmd.lk_wr      = 1'b1;
        cmd.wa_sel     = WA_AFTER;
        cmd.wd_sel     = WD_T;
        cmd.res_ld     = 1'b1;
        cmd.res_t      = 1'b1;
        cmd.res_status = ST_OK;
      end
      S_WCHK: begin
        if (sts.lkq_zero || sts.cnt_full) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_MISS;
        end else begin
          cmd.t_ld    = 1'b1;
          cmd.lk_rd   = 1'b1;
          cmd.rd_sel  = RD_LKQ;
          cmd.val_rd  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_WCMP: begin
        if (!sts.val_eq) begin
          cmd.prev_t = 1'b1;
        end else if (sts.op == OP_DELETE) begin
          // bypass the matched node, fetch the free head for the return
          cmd.lk_wr  = 1'b1;
          cmd.wa_sel = WA_PREV;
          cmd.wd_sel = WD_LKQ;
          cmd.lk_rd  = 1'b1;
          cmd.rd_sel = RD_ZERO;
        end else begin
          cmd.res_ld     = 1'b1;
          cmd.res_t      = 1'b1;
          cmd.res_status = ST_OK;
        end
      end
      S_DF1: begin
        cmd.lk_wr  = 1'b1;
        cmd.wa_sel = WA_T;
        cmd.wd_sel = WD_LKQ;
      end
      S_DF2: begin
        cmd.lk_wr      = 1'b1;
        cmd.wa_sel     = WA_ZERO;
        cmd.wd_sel     = WD_T;
        cmd.res_ld     = 1'b1;
        cmd.res_t      = 1'b1;
        cmd.res_status = ST_OK;
      end
      S_RESP: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/cll_dp.sv
`timescale 1ns / 1ps
// Datapath of the linked-list engine: link and value stores, walk registers,
// result and output registers. Depends on cll_pkg.
module cll_dp import cll_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_list_head,
  input  logic [7:0]  in_after_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_node,
  output logic [1:0]  out_status
);

  localparam int ADDR_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);

  logic [ADDR_W-1:0] link_mem [NODES];
  logic [31:0]       val_mem  [NODES];

  op_t               op_r;
  logic [31:0]       value_r;
  logic [7:0]        head_r;
  logic [7:0]        after_r;
  logic [ADDR_W-1:0] lk_q_r;
  logic [31:0]       vq_r;
  logic [ADDR_W-1:0] t_r;
  logic [ADDR_W-1:0] prev_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] ini_r;
  logic [7:0]        res_node_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r;
  logic [7:0]        out_node_r;
  logic [1:0]        out_status_r;

  logic [ADDR_W-1:0] head_idx, after_idx, rd_addr, wr_addr, wr_data, ini_next;
  logic              ini_last;

  assign head_idx  = ADDR_W'(head_r);
  assign after_idx = ADDR_W'(after_r);
  assign ini_last  = (ini_r == ADDR_W'(NODES - 1));
  assign ini_next  = ini_last ? '0 : ini_r + 1'b1;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_LKQ:   rd_addr = lk_q_r;
      RD_AFTER: rd_addr = after_idx;
      RD_HEAD:  rd_addr = head_idx;
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_ZERO:  wr_addr = '0;
      WA_T:     wr_addr = t_r;
      WA_AFTER: wr_addr = after_idx;
      WA_PREV:  wr_addr = prev_r;
      WA_INI:   wr_addr = ini_r;
      default:  wr_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_LKQ:  wr_data = lk_q_r;
      WD_ZERO: wr_data = '0;
      WD_T:    wr_data = t_r;
      WD_INI:  wr_data = ini_next;
      default: wr_data = '0;
    endcase
  end

  // link store: one write, one registered read; lk_q holds when not read
  always_ff @(posedge clk) begin
    if (cmd.lk_wr) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.lk_rd) begin
      lk_q_r <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      val_mem[t_r] <= value_r;
    end
    if (cmd.val_rd) begin
      vq_r <= val_mem[lk_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= op_t'(in_op);
      value_r <= in_value;
      head_r  <= in_list_head;
      after_r <= in_after_node;
    end
    if (cmd.t_ld) begin
      t_r <= lk_q_r;
    end
    if (cmd.prev_head) begin
      prev_r <= head_idx;
    end else if (cmd.prev_t) begin
      prev_r <= t_r;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.res_ld) begin
      res_node_r   <= cmd.res_t ? 8'(t_r) : 8'd0;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_node_r   <= res_node_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ini_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        ini_r <= ini_next;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.after_ok  = (after_r != 8'd0) && (32'(after_r) < 32'(NODES));
  assign sts.head_ok   = (head_r != 8'd0) && (32'(head_r) < 32'(NODES));
  assign sts.lkq_zero  = (lk_q_r == '0);
  assign sts.val_eq    = (vq_r == value_r);
  assign sts.cnt_full  = (cnt_r == CNT_W'(NODES));
  assign sts.init_last = ini_last;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_node   = out_node_r;
  assign out_status = out_status_r;

endmodule

FILE: sv/cursor_linked_list_engine.sv
`timescale 1ns / 1ps
// Cursor linked-list engine: NODES nodes, each a 32-bit value and a link,
// hold singly linked lists; node 0 heads the free list and is the null link.
// After reset a clearing pass over every node chains the free list; in_ready
// stays low until it ends. One request word is handled at a time and gives
// one response word. In a find or delete each node visited costs one
// registered read of the link and value stores and one compare. A rejected
// request (bad node number) answers with ST_MISS, an out-of-space make_list
// or insert with ST_FULL. A response still held in the output register
// stalls the next one until it is taken. The next request can be taken in
// the same cycle that the response is offered; the response register lets
// that happen while a response waits.
module cursor_linked_list_engine import cll_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input logic clk,
  input logic rst_n,
  cll_in_if.sink    in_ch,
  cll_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  cll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cll_dp #(.NODES(NODES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_ch.op),
    .in_value      (in_ch.value),
    .in_list_head  (in_ch.list_head),
    .in_after_node (in_ch.after_node),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_node      (out_ch.node),
    .out_status    (out_ch.status)
  );

  assign in_ch.ready = in_ready;

endmodule

FILE: sv/cll_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the linked-list engine, bound to the top level.
// Depends on cll_pkg.
module cll_chk import cll_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_node,
  input logic [1:0] out_status
);

  // hold a stalled response word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_status))
    else $error("response word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_MISS))
    else $error("undefined status code");

  a_fail_no_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_node == 8'd0)
    else $error("failed request reports a node");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in progress");

endmodule

bind cursor_linked_list_engine cll_chk u_cll_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_node   (out_ch.node),
  .out_status (out_ch.status)
);

FILE: tb/tb_cursor_linked_list_engine.sv
`timescale 1ns / 1ps
// Self-checking bench for cursor_linked_list_engine: directed table, then random
// list traffic checked word by word against a behavioural copy of the node store.
// Depends on cll_pkg, cll_in_if / cll_out_if and the engine RTL.
module tb_cursor_linked_list_engine;
  import cll_pkg::*;

  localparam int RAND_PER_PHASE = 634;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 2 * NODES_DEF + 16;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    logic [7:0]  head;
    logic [7:0]  after;
  } req_t;

  typedef struct packed {
    logic [7:0] node;
    logic [1:0] status;
  } reply_t;

  typedef struct {
    req_t   rq;
    bit     typed;
    reply_t want;
  } row_t;

  logic clk;
  logic rst_n;

  cll_in_if  in_ch ();
  cll_out_if out_ch ();

  cursor_linked_list_engine #(.NODES(NODES_DEF)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow node store
  logic [7:0]  link_mem  [0:NODES_DEF-1];
  logic [31:0] value_mem [0:NODES_DEF-1];
  bit          value_set [0:NODES_DEF-1];

  logic [7:0] list_heads[$];
  reply_t     pending_replies[$];
  row_t       directed_rows[$];

  bit     filling_store;
  bit     cur_typed;
  reply_t cur_want;
  int     src_idle_pct;
  int     sink_idle_pct;
  bit     hold_req;

  int mismatches;
  int n_op [0:3];
  int n_ok, n_full, n_miss, n_replies;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("tb_cursor_linked_list_engine NOT OK");
    $finish;
  end

  // Apply one request to the shadow store. With commit low nothing changes and
  // the return value tells whether the walk stays on nodes that hold a value.
  function automatic bit list_op(input req_t rq, input bit commit, output reply_t rp);
    logic [7:0] p, t;
    int steps;
    bit clean;
    clean = 1'b1;
    rp.node = 8'd0;
    rp.status = ST_OK;
    case (rq.op)
      OP_MAKE: begin
        t = link_mem[0];
        if (t == 8'd0) begin
          rp.status = ST_FULL;
        end else begin
          if (commit) begin
            link_mem[0] = link_mem[t];
            link_mem[t] = 8'd0;
          end
          rp.node = t;
        end
      end
      OP_INSERT: begin
        if (rq.after == 8'd0) begin
          rp.status = ST_MISS;
        end else begin
          t = link_mem[0];
          if (t == 8'd0) begin
            rp.status = ST_FULL;
          end else begin
            if (commit) begin
              link_mem[0] = link_mem[t];
              value_mem[t] = rq.value;
              value_set[t] = 1'b1;
              link_mem[t] = link_mem[rq.after];
              link_mem[rq.after] = t;
            end
            rp.node = t;
          end
        end
      end
      OP_DELETE: begin
        rp.status = ST_MISS;
        if (rq.head != 8'd0) begin
          p = rq.head;
          for (steps = 0; steps < NODES_DEF; steps++) begin
            t = link_mem[p];
            if (t == 8'd0) break;
            if (!value_set[t]) begin
              clean = 1'b0;
              break;
            end
            if (value_mem[t] == rq.value) begin
              if (commit) begin
                link_mem[p] = link_mem[t];
                link_mem[t] = link_mem[0];
                link_mem[0] = t;
              end
              rp.node = t;
              rp.status = ST_OK;
              break;
            end
            p = t;
          end
        end
      end
      default: begin
        rp.status = ST_MISS;
        if (rq.head != 8'd0) begin
          p = link_mem[rq.head];
          for (steps = 0; steps < NODES_DEF && p != 8'd0; steps++) begin
            if (!value_set[p]) begin
              clean = 1'b0;
              break;
            end
            if (value_mem[p] == rq.value) begin
              rp.node = p;
              rp.status = ST_OK;
              break;
            end
            p = link_mem[p];
          end
        end
      end
    endcase
    return clean;
  endfunction

  function automatic void add_row(input op_t op, input logic [31:0] v, input logic [7:0] h,
                                  input logic [7:0] a, input bit typed,
                                  input logic [7:0] node, input logic [1:0] st);
    row_t r;
    r.rq.op = op;
    r.rq.value = v;
    r.rq.head = h;
    r.rq.after = a;
    r.typed = typed;
    r.want.node = node;
    r.want.status = st;
    directed_rows.push_back(r);
  endfunction

  // Mostly well-formed traffic on the known lists, with some stray node numbers.
  function automatic req_t pick_request();
    req_t rq;
    reply_t unused;
    logic [7:0] h, n;
    int r, k;
    r = $urandom_range(0, 99);
    rq.op = OP_FIND;
    rq.value = $urandom;
    rq.head = 8'($urandom_range(0, 255));
    rq.after = 8'($urandom_range(0, 255));
    if (list_heads.size() == 0 ||
        (r < 5 && (list_heads.size() < 8 || link_mem[0] == 8'd0))) begin
      rq.op = OP_MAKE;
    end else if (r >= 5 && r < 7) begin
      rq.op = op_t'($urandom_range(1, 3));
    end else begin
      h = list_heads[$urandom_range(0, list_heads.size() - 1)];
      n = h;
      for (k = $urandom_range(0, 40); k > 0 && link_mem[n] != 8'd0; k--) n = link_mem[n];
      if (n != h && $urandom_range(0, 3) != 0) rq.value = value_mem[n];
      else if ($urandom_range(0, 7) == 0) rq.value = $urandom_range(0, 3);
      rq.head = h;
      if (r < (filling_store ? 72 : 17)) begin
        rq.op = OP_INSERT;
        rq.after = $urandom_range(0, 1) ? h : n;
      end else if (r < (filling_store ? 80 : 72)) begin
        rq.op = OP_DELETE;
      end
    end
    // never walk onto a node whose value was never written
    if ((rq.op == OP_DELETE || rq.op == OP_FIND) && !list_op(rq, 1'b0, unused))
      rq.head = 8'd0;
    return rq;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input req_t rq, input bit typed, input reply_t want);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk);
    end
    cur_typed = typed;
    cur_want = want;
    in_ch.valid <= 1'b1;
    in_ch.op <= rq.op;
    in_ch.value <= rq.value;
    in_ch.list_head <= rq.head;
    in_ch.after_node <= rq.after;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic flag_mismatch(input string what, input reply_t want,
                               input logic [7:0] node, input logic [1:0] st);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%t: %s: expected node %0d status %0d, got node %0d status %0d",
               $realtime, what, want.node, want.status, node, st);
  endtask

  // predict on every accepted request word
  always @(posedge clk) begin : watch_requests
    req_t rq;
    reply_t rp;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rq.op = op_t'(in_ch.op);
      rq.value = in_ch.value;
      rq.head = in_ch.list_head;
      rq.after = in_ch.after_node;
      void'(list_op(rq, 1'b1, rp));
      if (rq.op == OP_MAKE && rp.status == ST_OK) list_heads.push_back(rp.node);
      n_op[rq.op]++;
      if (rp.status == ST_OK) n_ok++;
      else if (rp.status == ST_FULL) n_full++;
      else n_miss++;
      pending_replies.push_back(cur_typed ? cur_want : rp);
    end
  end

  always @(posedge clk) begin : watch_replies
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        want = '0;
        flag_mismatch("reply with none pending", want, out_ch.node, out_ch.status);
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.node !== want.node || out_ch.status !== want.status)
          flag_mismatch("reply mismatch", want, out_ch.node, out_ch.status);
      end
    end
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    req_t rq;
    reply_t none;
    int phase, k, full_seen, drain_left;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_MAKE;
    in_ch.value = '0;
    in_ch.list_head = '0;
    in_ch.after_node = '0;
    hold_req = 1'b0;
    cur_typed = 1'b0;
    cur_want = '0;
    none = '0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    filling_store = 1'b1;
    mismatches = 0;
    n_ok = 0;
    n_full = 0;
    n_miss = 0;
    n_replies = 0;
    for (int i = 0; i < 4; i++) n_op[i] = 0;
    for (int i = 0; i < NODES_DEF; i++) begin
      link_mem[i] = 8'((i + 1) % NODES_DEF);
      value_mem[i] = '0;
      value_set[i] = 1'b0;
    end

    // op, value, head, after, typed, node, status
    add_row(OP_MAKE,   32'h0000_0000, 8'd0,   8'd0,   1'b1, 8'd1, ST_OK);
    add_row(OP_INSERT, 32'h0000_0000, 8'd0,   8'd1,   1'b0, 8'd0, ST_OK);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 8'd0,   8'd1,   1'b0, 8'd0, ST_OK);
    add_row(OP_INSERT, 32'hA5A5_5A5A, 8'd0,   8'd2,   1'b0, 8'd0, ST_OK);
    add_row(OP_INSERT, 32'h0000_1234, 8'd0,   8'd0,   1'b1, 8'd0, ST_MISS);
    add_row(OP_FIND,   32'h0000_0000, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'hFFFF_FFFF, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'h1234_5678, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'h0000_0000, 8'd0,   8'd0,   1'b1, 8'd0, ST_MISS);
    add_row(OP_DELETE, 32'h0000_0000, 8'd0,   8'd0,   1'b1, 8'd0, ST_MISS);
    add_row(OP_DELETE, 32'h1234_5678, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_MAKE,   32'h0000_0000, 8'd0,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_INSERT, 32'h8000_0001, 8'd0,   8'd3,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'h8000_0001, 8'd3,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'h0000_0000, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'hA5A5_5A5A, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'hA5A5_5A5A, 8'd1,   8'd0,   1'b0, 8'd0, ST_OK);
    // insert after the node at the head of the free list: it links to itself
    add_row(OP_INSERT, 32'h7FFF_FFFE, 8'd0,   8'd4,   1'b0, 8'd0, ST_OK);
    add_row(OP_FIND,   32'h0000_0001, 8'd4,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'h0000_0001, 8'd4,   8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'h7FFF_FFFE, 8'd4,   8'd0,   1'b0, 8'd0, ST_OK);
    // free node used as a list header
    add_row(OP_FIND,   32'h0000_0005, 8'd255, 8'd0,   1'b0, 8'd0, ST_OK);
    add_row(OP_DELETE, 32'h0000_0005, 8'd255, 8'd255, 1'b0, 8'd0, ST_OK);
    add_row(OP_MAKE,   32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0, 8'd0, ST_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    drain_replies();

    full_seen = 0;
    drain_left = 0;
    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
      sink_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (k == RAND_PER_PHASE / 2 && phase != 1) hold_req = 1'b1;
        // fill the store until it runs out, then drain it for a while
        if (filling_store && link_mem[0] == 8'd0) full_seen++;
        if (filling_store && full_seen >= 6) begin
          filling_store = 1'b0;
          drain_left = 200;
        end else if (!filling_store) begin
          drain_left--;
          if (drain_left == 0) begin
            filling_store = 1'b1;
            full_seen = 0;
          end
        end
        rq = pick_request();
        offer_word(rq, 1'b0, none);
      end
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d requests: %0d make, %0d insert, %0d delete, %0d find; %0d replies",
             n_op[0] + n_op[1] + n_op[2] + n_op[3], n_op[OP_MAKE], n_op[OP_INSERT],
             n_op[OP_DELETE], n_op[OP_FIND], n_replies);
    $display("%0d ok, %0d out of space, %0d not found or rejected, %0d mismatches",
             n_ok, n_full, n_miss, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb_cursor_linked_list_engine OK");
    end else begin
      $display("tb_cursor_linked_list_engine NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/cll_pkg.sv
sv/cll_if.sv
sv/cll_ctrl.sv
sv/cll_dp.sv
sv/cursor_linked_list_engine.sv
sv/cll_chk.sv
tb/tb_cursor_linked_list_engine.sv
